### src/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Item types, round constants, initial hash values and sequencer states.
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_const(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[r];
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{
			32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
		};
		return h[i];
	endfunction

endpackage

### src/sha256_message_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Byte-stream SHA-256 with padding and word-serial digest output.
// ----------------------------------------------------------------------------
// The 64th byte of a block starts a compression: a load step, the rounds on
// a single shared round unit and the final add of the eight hash words,
// during which the core is not ready. End of message writes the 0x80 byte,
// the zero fill and the length one byte per cycle up to the end of the block
// and compresses. When the length does not fit, or the last byte filled the
// block, a second fill of a whole block and compression follow. The eight
// digest words then go out one per accepted output item, after which the
// core is ready for the next message.
module sha256_message_hasher_core import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	state_t state_q, state_d;

	logic [31:0] blk_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [60:0] cnt_q;
	logic [5:0]  pos_q;
	logic [6:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        fin_q;
	logic        pend_q;
	logic        mark_q;
	logic [63:0] bits_q;

	logic        acc;
	logic [5:0]  r;
	logic [60:0] cnt_inc;
	logic [31:0] w_new, a2, a15, s0, s1, t1, t2, wm;
	logic [7:0]  pad_byte;

	assign acc = in_valid && in_ready;
	assign r = rnd_q[5:0];
	assign cnt_inc = cnt_q + 61'(in_data.has_byte);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		wm = blk_q[r[3:0]];
		a2 = w_q[4'(r - 6'd2)];
		a15 = w_q[4'(r - 6'd15)];
		s0 = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
		s1 = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
		w_new = (r < 6'd16) ? wm : s1 + w_q[4'(r - 6'd7)] + s0 + w_q[r[3:0]];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_const(r) + w_new;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		if (mark_q)
			pad_byte = PAD_BYTE;
		else if (pos_q >= 6'd56 && fin_q)
			pad_byte = bits_q[{~pos_q[2:0], 3'b111} -: 8];
		else
			pad_byte = 8'h00;
	end

	// fin_q: length field belongs in this block
	// pend_q: another padding block follows this compression
	// mark_q: next padding byte is 0x80

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_data.has_byte && cnt_q[5:0] == 6'd63)
						state_d = ST_LOAD;
					else if (in_data.end_of_message)
						state_d = ST_PAD;
				end
			end
			ST_PAD: if (pos_q == 6'd63) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 7'd63) state_d = ST_ADD;
			ST_ADD: begin
				if (idx_q == 3'd7) begin
					if (fin_q) state_d = ST_EMIT;
					else if (pend_q) state_d = ST_PAD;
					else state_d = ST_IDLE;
				end
			end
			ST_EMIT: if (out_ready && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		out_data.digest_word = h_q[idx_q];
		out_data.word_index = idx_q;
		out_data.last_word = (idx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			pend_q <= 1'b0;
			mark_q <= 1'b0;
			bits_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (in_data.has_byte) begin
							blk_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b111} -: 8] <= in_data.data_byte;
							cnt_q <= cnt_q + 61'd1;
						end
						if (in_data.end_of_message) begin
							bits_q <= {cnt_inc, 3'b000};
							mark_q <= 1'b1;
							if (in_data.has_byte && cnt_q[5:0] == 6'd63) begin
								fin_q <= 1'b0;
								pend_q <= 1'b1;
							end else begin
								pos_q <= cnt_inc[5:0];
								fin_q <= (cnt_inc[5:0] < 6'd56);
								pend_q <= !(cnt_inc[5:0] < 6'd56);
							end
						end else begin
							fin_q <= 1'b0;
							pend_q <= 1'b0;
							mark_q <= 1'b0;
						end
					end
				end
				ST_PAD: begin
					blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b111} -: 8] <= pad_byte;
					mark_q <= 1'b0;
					pos_q <= pos_q + 6'd1;
				end
				ST_LOAD: begin
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					rnd_q <= '0;
				end
				ST_ROUND: begin
					w_q[r[3:0]] <= w_new;
					for (int i = 1; i < 8; i++) if (i != 4) v_q[i] <= v_q[i - 1];
					v_q[4] <= v_q[3] + t1;
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 7'd1;
					idx_q <= '0;
				end
				ST_ADD: begin
					h_q[idx_q] <= h_q[idx_q] + v_q[idx_q];
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7 && !fin_q && pend_q) begin
						pos_q <= 6'd0;
						fin_q <= 1'b1;
						pend_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						h_q[idx_q] <= init_hash(idx_q);
						if (idx_q == 3'd7) begin
							cnt_q <= '0;
							fin_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### bench/tb_sha256_message_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher core testbench
// Streams byte messages of assorted lengths, with idle items, into the core
// and compares every digest word against a built-in SHA-256 predictor, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher_core import sha256_pkg::*;;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	sha256_message_hasher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0] hash_st [8];
	logic [7:0]  blk [64];
	logic [60:0] msg_len;
	out_item_t   digest_q [$];
	int          errors;
	int          words_seen;
	int          msgs_sent;
	int          items_sent;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] v [8];
		logic [31:0] w [64];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 8; i++) v[i] = hash_st[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
			end else begin
				s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
				s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
				w[r] = s1 + w[r-7] + s0 + w[r-16];
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
	endtask

	task automatic predict_hash(in_item_t it);
		int          pos;
		logic [63:0] bits;
		out_item_t   o;
		if (it.has_byte) begin
			pos = int'(msg_len[5:0]);
			blk[pos] = it.data_byte;
			msg_len = msg_len + 61'd1;
			if (pos == 63) compress();
		end
		if (!it.end_of_message) return;
		pos = int'(msg_len[5:0]);
		bits = {msg_len, 3'b000};
		blk[pos] = PAD_BYTE;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk[pos] = 8'h00;
				pos++;
			end
			compress();
			pos = 0;
		end
		while (pos < 56) begin
			blk[pos] = 8'h00;
			pos++;
		end
		for (int k = 0; k < 8; k++) blk[56+k] = bits[63-8*k -: 8];
		compress();
		for (int k = 0; k < 8; k++) begin
			o.digest_word = hash_st[k];
			o.word_index = 3'(k);
			o.last_word = (k == 7);
			digest_q = {digest_q, o};
		end
		for (int i = 0; i < 8; i++) hash_st[i] = IV[i];
		msg_len = '0;
		msgs_sent++;
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(logic [7:0] b, logic hb, logic eom);
		in_item_t it;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		it.data_byte = b;
		it.has_byte = hb;
		it.end_of_message = eom;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_hash(it);
		items_sent++;
	endtask

	task automatic send_message(int n, int mode);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: b = 8'h00;
				1: b = 8'hff;
				default: b = 8'($urandom);
			endcase
			if (i == n - 1 && $urandom_range(0, 1)) begin
				send_item(b, 1'b1, 1'b1);
				return;
			end
			send_item(b, 1'b1, 1'b0);
			if (mode > 1 && $urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
		end
		send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_empty_message();
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h5a, 1'b0, 1'b1);
	endtask

	task automatic test_byte_extremes();
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_pad_boundaries();
		send_message(56, 0);
		send_message(64, 2);
	endtask

	task automatic test_random_messages();
		int n;
		while (items_sent < 170) begin
			n = $urandom_range(0, 20);
			send_message(n, 2);
		end
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest item %h", out_data);
				errors++;
			end else begin
				e = digest_q.pop_front();
				words_seen++;
				if (out_data.digest_word !== e.digest_word) begin
					$error("digest_word exp %h got %h", e.digest_word, out_data.digest_word);
					errors++;
				end
				if (out_data.word_index !== e.word_index) begin
					$error("word_index exp %0d got %0d", e.word_index, out_data.word_index);
					errors++;
				end
				if (out_data.last_word !== e.last_word) begin
					$error("last_word exp %0d got %0d", e.last_word, out_data.last_word);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) out_ready <= 1'b1;
		else if (p < 95) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 3) == 0);
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		errors = 0;
		words_seen = 0;
		msgs_sent = 0;
		items_sent = 0;
		for (int i = 0; i < 8; i++) hash_st[i] = IV[i];
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		msg_len = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_message();
		test_byte_extremes();
		test_pad_boundaries();
		test_random_messages();
		in_valid <= 1'b0;
		w = 0;
		while (digest_q.size() != 0 && w < 200000) begin
			@(posedge clk);
			w++;
		end
		repeat (200) @(posedge clk);
		$display("Hashed %0d messages over %0d input items, %0d digest words checked.",
			msgs_sent, items_sent, words_seen);
		if (errors == 0 && digest_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### files.f
src/sha256_pkg.sv
src/sha256_message_hasher_core.sv
bench/tb_sha256_message_hasher_core.sv
